### rtl/cua_pkg.sv
// Shared constants, codes and types of the contiguous unit allocator.
package cua_pkg;

	localparam int PARTITION_BYTES = 65536;
	localparam int MAX_UNITS       = 1024;
	localparam int UNIT_W          = $clog2(MAX_UNITS);
	localparam int CNT_W           = UNIT_W + 1;
	localparam int SIZE_W          = 13;
	localparam int BYTE_W          = 16;
	localparam int OWN_W           = 4;
	localparam int DVD_W           = $clog2(PARTITION_BYTES) + 1;
	localparam int DVS_W           = SIZE_W;
	localparam int CFG_IDX_W       = 1;

	localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(64);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(4096);
	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);
	localparam logic [CNT_W-1:0]  TOTAL_RESET =
		CNT_W'((PARTITION_BYTES / 64 > MAX_UNITS) ? MAX_UNITS : PARTITION_BYTES / 64);
	localparam logic [CNT_W-1:0]  UNITS_CAP  = CNT_W'(MAX_UNITS);

	typedef enum logic [1:0] {
		FIT_FIRST     = 2'd0,
		FIT_BEST      = 2'd1,
		FIT_WORST     = 2'd2,
		FIT_FIRST_ALT = 2'd3
	} fit_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_ZERO    = 2'd1,
		STAT_NOSPACE = 2'd2,
		STAT_RANGE   = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT       = 1'b0,
		CFG_UNIT_SIZE = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		FN_ALLOC   = 1'b0,
		FN_RELEASE = 1'b1
	} func_t;

	typedef struct packed {
		logic [CNT_W-1:0] len;
		logic [OWN_W-1:0] owner;
	} seg_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CDIV,
		S_DIV,
		S_AWALK,
		S_AFIN,
		S_AWR_PICK,
		S_RWALK,
		S_RNEXT,
		S_RWR,
		S_MUL,
		S_EMIT
	} state_t;

endpackage

### rtl/cua_if.sv
// Handshake channels of the allocator: request, response and config write.
interface cua_req_if;
	import cua_pkg::*;
	logic                valid;
	logic                ready;
	logic                func;
	logic [BYTE_W-1:0]   request_bytes;
	logic [OWN_W-1:0]    owner_type;
	logic [BYTE_W-1:0]   release_offset;
	modport source (output valid, func, request_bytes, owner_type, release_offset,
		input ready);
	modport sink (input valid, func, request_bytes, owner_type, release_offset,
		output ready);
endinterface

interface cua_rsp_if;
	import cua_pkg::*;
	logic                valid;
	logic                ready;
	logic [1:0]          status;
	logic [UNIT_W-1:0]   start_unit;
	logic [CNT_W-1:0]    unit_count;
	logic [BYTE_W-1:0]   byte_offset;
	logic [OWN_W-1:0]    released_owner;
	logic [CNT_W-1:0]    free_units;
	modport source (output valid, status, start_unit, unit_count, byte_offset,
		released_owner, free_units, input ready);
	modport sink (input valid, status, start_unit, unit_count, byte_offset,
		released_owner, free_units, output ready);
endinterface

interface cua_cfg_if;
	import cua_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### rtl/cua_div.sv
// Restoring divider, one quotient bit per cycle.
module cua_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cua_pkg::DVD_W-1:0] dividend,
	input  logic [cua_pkg::DVS_W-1:0] divisor,
	output logic                     done,
	output logic [cua_pkg::DVD_W-1:0] quotient
);
	import cua_pkg::*;

	localparam int CW = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [DVD_W-1:0]  quo_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [DVS_W:0]    trial;
	logic              take;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			// remainder stays below the divisor, so it fits DVS_W bits
			rem_q <= take ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/cua_seg_mem.sv
// Segment table: length and owner per start unit, one write and one read port.
module cua_seg_mem (
	input  logic                      clk,
	input  logic                      we,
	input  logic [cua_pkg::UNIT_W-1:0] waddr,
	input  cua_pkg::seg_t             wdata,
	input  logic                      re,
	input  logic [cua_pkg::UNIT_W-1:0] raddr,
	output cua_pkg::seg_t             rdata
);
	import cua_pkg::*;

	seg_t mem_q [MAX_UNITS];
	seg_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/contiguous_unit_allocator.sv
// Contiguous unit allocator top level: sequencer, segment walk and result register.
//
// Usage:
//  - req channel: one beat is one operation, func 0 allocates request_bytes
//    for owner_type, func 1 releases the segment holding release_offset.
//  - rsp channel: one beat per request with status, segment start, unit
//    count, byte offset, released owner and total free units afterwards.
//  - cfg channel: index 0 sets fit_policy, index 1 sets the unit size (64..4096)
//    and rebuilds the partition as one free segment; other sizes are dropped.
//    Write it only while no request is in flight.
// Flow: a request first runs through the shared divider (units needed or
//  unit index of the offset), then walks the segments one after another
//  on the table read port, then updates the table, forms the byte offset
//  and loads the result. A zero request skips the divider and the table.
//  A size write also runs through the divider and then rewrites the table.
// Reset: fit_policy first fit, unit size 64, one free segment of all
//  units; the block writes it in its init state before taking requests.
// Backpressure: the result sits in an output register; a new request is
//  taken while it waits, and the block holds in its last step until the
//  register is free.
module contiguous_unit_allocator (
	input  logic clk,
	input  logic arst_n,
	cua_req_if.sink   req,
	cua_rsp_if.source rsp,
	cua_cfg_if.sink   cfg
);
	import cua_pkg::*;

	localparam int END_W = CNT_W + 1;
	localparam int PROD_W = UNIT_W + SIZE_W;

	state_t state_q, state_d;

	// configuration and global state
	fit_t              fit_q;
	logic [SIZE_W-1:0] usize_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  free_q;

	// current operation
	logic              func_q;
	logic [OWN_W-1:0]  own_q;
	logic [CNT_W-1:0]  key_q;      // units needed, or unit index to release
	logic [UNIT_W-1:0] s_q;        // segment being looked at

	logic              found_q;
	logic [UNIT_W-1:0] pick_q;
	logic [CNT_W-1:0]  pick_len_q;

	logic              has_prev_q;
	logic              prev_free_q;
	logic [UNIT_W-1:0] prev_q;
	logic [CNT_W-1:0]  prev_len_q;
	logic [CNT_W-1:0]  hit_len_q;
	logic [OWN_W-1:0]  hit_own_q;

	// pending result
	status_t           res_stat_q;
	logic [UNIT_W-1:0] res_start_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic [OWN_W-1:0]  res_own_q;
	logic [BYTE_W-1:0] prod_q;

	// output register
	logic              out_valid_q;
	status_t           out_stat_q;
	logic [UNIT_W-1:0] out_start_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic [BYTE_W-1:0] out_bytes_q;
	logic [OWN_W-1:0]  out_own_q;
	logic [CNT_W-1:0]  out_free_q;

	// control
	logic              req_acc, cfg_acc, size_ok, out_load;
	logic              div_start, div_done;
	logic [DVD_W-1:0]  div_dvd, div_q;
	logic              mem_we, mem_re;
	logic [UNIT_W-1:0] mem_waddr, mem_raddr;
	seg_t              mem_wdata, mem_rdata;

	// walk decisions
	logic [END_W-1:0]  seg_end;
	logic              at_end, fits, take_first, better, stop_first, awalk_done;
	logic              hit;
	logic [CNT_W-1:0]  nx_len, merged_len;
	logic [UNIT_W-1:0] merged_start;

	assign req_acc  = req.valid && req.ready;
	assign cfg_acc  = cfg.valid && cfg.ready;
	assign size_ok  = (cfg.data >= SIZE_MIN) && (cfg.data <= SIZE_MAX);
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	assign seg_end    = END_W'(s_q) + END_W'(mem_rdata.len);
	assign at_end     = seg_end >= END_W'(total_q);
	assign fits       = (mem_rdata.owner == '0) && (mem_rdata.len >= key_q);
	assign take_first = fits && !found_q;
	assign better     = fits && found_q &&
		(((fit_q == FIT_BEST) && (mem_rdata.len < pick_len_q)) ||
		 ((fit_q == FIT_WORST) && (mem_rdata.len > pick_len_q)));
	assign stop_first = take_first && (fit_q != FIT_BEST) && (fit_q != FIT_WORST);
	assign awalk_done = stop_first || at_end;
	assign hit        = END_W'(key_q) < seg_end;

	// coalesce: free right neighbor, then free left neighbor
	assign nx_len       = ((state_q == S_RNEXT) && (mem_rdata.owner == '0)) ?
		mem_rdata.len : '0;
	assign merged_start = (has_prev_q && prev_free_q) ? prev_q : s_q;
	assign merged_len   = hit_len_q + nx_len +
		((has_prev_q && prev_free_q) ? prev_len_q : CNT_W'(0));

	cua_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_start && cfg_acc ? cfg.data : usize_q),
		.done     (div_done),
		.quotient (div_q)
	);

	cua_seg_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: state_d = S_IDLE;
			S_IDLE: begin
				if (cfg_acc) begin
					if ((cfg.index == CFG_UNIT_SIZE) && size_ok) state_d = S_CDIV;
				end else if (req_acc) begin
					if ((req.func == FN_ALLOC) && (req.request_bytes == '0)) state_d = S_MUL;
					else state_d = S_DIV;
				end
			end
			S_CDIV: if (div_done) state_d = S_INIT;
			S_DIV: begin
				if (div_done) begin
					if (func_q == FN_ALLOC) state_d = S_AWALK;
					else if (div_q[CNT_W-1:0] >= total_q) state_d = S_MUL;
					else state_d = S_RWALK;
				end
			end
			S_AWALK: if (awalk_done) state_d = S_AFIN;
			S_AFIN: state_d = found_q ? S_AWR_PICK : S_MUL;
			S_AWR_PICK: state_d = S_MUL;
			S_RWALK: begin
				if (hit) state_d = at_end ? S_RWR : S_RNEXT;
				else if (at_end) state_d = S_MUL;
			end
			S_RNEXT: state_d = S_MUL;
			S_RWR: state_d = S_MUL;
			S_MUL: state_d = S_EMIT;
			S_EMIT: if (out_load) state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cfg.ready = 1'b0;
		req.ready = 1'b0;
		div_start = 1'b0;
		div_dvd   = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = '{len: total_q, owner: '0};
			end
			S_IDLE: begin
				cfg.ready = 1'b1;
				req.ready = !cfg.valid;
				if (cfg_acc && (cfg.index == CFG_UNIT_SIZE) && size_ok) begin
					div_start = 1'b1;
					div_dvd   = DVD_W'(PARTITION_BYTES);
				end else if (req_acc) begin
					div_start = !((req.func == FN_ALLOC) && (req.request_bytes == '0));
					div_dvd   = (req.func == FN_ALLOC) ?
						DVD_W'(req.request_bytes) + DVD_W'(usize_q) - DVD_W'(1) :
						DVD_W'(req.release_offset);
				end
			end
			S_DIV: begin
				mem_re = div_done;
			end
			S_AWALK: begin
				mem_re    = !awalk_done;
				mem_raddr = seg_end[UNIT_W-1:0];
			end
			S_AFIN: begin
				// split off the remainder as a free segment
				mem_we    = found_q && (pick_len_q > key_q);
				mem_waddr = pick_q + key_q[UNIT_W-1:0];
				mem_wdata = '{len: pick_len_q - key_q, owner: '0};
			end
			S_AWR_PICK: begin
				mem_we    = 1'b1;
				mem_waddr = pick_q;
				mem_wdata = '{len: key_q, owner: own_q};
			end
			S_RWALK: begin
				mem_re    = !at_end;
				mem_raddr = seg_end[UNIT_W-1:0];
			end
			S_RNEXT, S_RWR: begin
				mem_we    = 1'b1;
				mem_waddr = merged_start;
				mem_wdata = '{len: merged_len, owner: '0};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			fit_q       <= FIT_FIRST;
			usize_q     <= SIZE_RESET;
			total_q     <= TOTAL_RESET;
			free_q      <= TOTAL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				if (cfg.index == CFG_FIT) fit_q <= fit_t'(cfg.data[1:0]);
				else if (size_ok) usize_q <= cfg.data;
			end
			if ((state_q == S_CDIV) && div_done) begin
				total_q <= (div_q > DVD_W'(UNITS_CAP)) ? UNITS_CAP : div_q[CNT_W-1:0];
			end
			if (state_q == S_INIT) free_q <= total_q;
			if ((state_q == S_AWR_PICK) && (own_q != '0)) free_q <= free_q - key_q;
			if (((state_q == S_RNEXT) || (state_q == S_RWR)) && (hit_own_q != '0)) begin
				free_q <= free_q + hit_len_q;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// operation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q      <= req.func;
				own_q       <= req.owner_type;
				found_q     <= 1'b0;
				has_prev_q  <= 1'b0;
				s_q         <= '0;
				res_stat_q  <= STAT_ZERO;
				res_start_q <= '0;
				res_cnt_q   <= '0;
				res_own_q   <= '0;
			end
			S_DIV: begin
				key_q      <= div_q[CNT_W-1:0];
				res_stat_q <= STAT_RANGE;
			end
			S_AWALK: begin
				if (take_first || better) begin
					found_q    <= 1'b1;
					pick_q     <= s_q;
					pick_len_q <= mem_rdata.len;
				end
				s_q <= seg_end[UNIT_W-1:0];
			end
			S_AFIN: begin
				res_stat_q <= found_q ? STAT_OK : STAT_NOSPACE;
				res_start_q <= found_q ? pick_q : '0;
				res_cnt_q   <= found_q ? key_q : '0;
			end
			S_RWALK: begin
				if (hit) begin
					hit_len_q   <= mem_rdata.len;
					hit_own_q   <= mem_rdata.owner;
					res_stat_q  <= STAT_OK;
					res_start_q <= s_q;
					res_cnt_q   <= mem_rdata.len;
					res_own_q   <= mem_rdata.owner;
				end else begin
					has_prev_q  <= 1'b1;
					prev_q      <= s_q;
					prev_len_q  <= mem_rdata.len;
					prev_free_q <= mem_rdata.owner == '0;
					s_q         <= seg_end[UNIT_W-1:0];
				end
			end
			S_MUL: begin
				prod_q <= BYTE_W'(PROD_W'(res_start_q) * PROD_W'(usize_q));
			end
			default: ;
		endcase
		if (out_load) begin
			out_stat_q  <= res_stat_q;
			out_start_q <= res_start_q;
			out_cnt_q   <= res_cnt_q;
			out_bytes_q <= prod_q;
			out_own_q   <= res_own_q;
			out_free_q  <= free_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_stat_q;
	assign rsp.start_unit     = out_start_q;
	assign rsp.unit_count     = out_cnt_q;
	assign rsp.byte_offset    = out_bytes_q;
	assign rsp.released_owner = out_own_q;
	assign rsp.free_units     = out_free_q;

endmodule
